/* src/sstr_pkg.sv */
// ----------------------------------------------------------------------------
// Sparse triple transpose package
// Shared word layouts and register indexes for the sparse transpose block.
// ----------------------------------------------------------------------------
`default_nettype none

package sstr_pkg;

    // Width of a matrix index and of an element value.
    localparam int IDX_W = 7;
    localparam int VAL_W = 32;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_NUM_ROWS = 1'b0,
        REG_NUM_COLS = 1'b1
    } cfg_idx_t;

    // One stored triple.
    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } triple_t;

    // Input word.
    typedef struct packed {
        logic [IDX_W-1:0]        src_row;
        logic [IDX_W-1:0]        src_col;
        logic signed [VAL_W-1:0] elem_value;
        logic                    has_entry;
        logic                    last_in;
    } in_word_t;

    // Output word.
    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [VAL_W-1:0] out_value;
        logic                    out_valid_entry;
        logic                    overflow;
        logic                    last_out;
    } out_word_t;

endpackage

`default_nettype wire

/* src/sparse_triple_fast_transpose.sv */
// ----------------------------------------------------------------------------
// Sparse triple fast transpose
// Collects coordinate triples, counts entries per column, and on the last
// word emits the transposed triples ordered by source column, or one empty word.
// ----------------------------------------------------------------------------
// Loading: a stored triple takes a read-modify-write of its column count in
//   the column memory; no new input word is accepted until it is done.
// After the last word: a prefix pass over the counts, the scatter of the
//   triples, emission of the results (held by output stalls), then a pass
//   that zeroes the column memory.
// Reset: control registers clear at once; a clearing pass of the column
//   memory follows, during which no input word is accepted.
`default_nettype none

module sparse_triple_fast_transpose #(
    parameter int MAX_ENTRIES = 64,
    parameter int MAX_DIM     = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire sstr_pkg::cfg_idx_t cfg_index,
    input  wire logic [6:0]         cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire sstr_pkg::in_word_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output sstr_pkg::out_word_t     out_data
);
    import sstr_pkg::*;

    // Derived widths.
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int DIW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W = DIW + 1;
    localparam int SAW   = $clog2(2 * MAX_ENTRIES);
    localparam int SDEPTH = 2 * MAX_ENTRIES;

    typedef enum logic [9:0] {
        S_CLR   = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_UPD   = 10'b0000000100,
        S_PFX   = 10'b0000001000,
        S_SC_RD = 10'b0000010000,
        S_SC_ST = 10'b0000100000,
        S_SC_WR = 10'b0001000000,
        S_EM_RD = 10'b0010000000,
        S_EM_LD = 10'b0100000000,
        S_EMPTY = 10'b1000000000
    } state_t;

    // Control registers.
    state_t           state_reg, state_next;
    logic [6:0]       num_rows_reg, num_rows_next;
    logic [6:0]       num_cols_reg, num_cols_next;
    logic [CW-1:0]    total_reg, total_next;
    logic             dropped_reg, dropped_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             pv_reg, pv_next;
    logic [DIW-1:0]   pa_reg, pa_next;
    logic [CW-1:0]    sum_reg, sum_next;
    logic [CW-1:0]    k_reg, k_next;
    logic [DIW-1:0]   caddr_reg, caddr_next;
    logic             last_reg, last_next;
    triple_t          t_reg, t_next;

    // Column memory: counts while loading, slot offsets while scattering.
    logic [CW-1:0]    col_mem [MAX_DIM];
    logic             col_rd_en;
    logic [DIW-1:0]   col_rd_addr;
    logic [CW-1:0]    col_rdata_reg;
    logic             col_wr_en;
    logic [DIW-1:0]   col_wr_addr;
    logic [CW-1:0]    col_wr_data;

    // Triple memory: lower half in arrival order, upper half in output order.
    triple_t          st_mem [SDEPTH];
    logic             st_rd_en;
    logic [SAW-1:0]   st_rd_addr;
    triple_t          st_rdata_reg;
    logic             st_wr_en;
    logic [SAW-1:0]   st_wr_addr;
    triple_t          st_wr_data;

    // Output stage interface.
    logic             ld_en;
    out_word_t        ld_word;
    logic             ld_free;

    // Range checks of the incoming word.
    logic             row_ok, col_ok, room_ok, item_ok;
    logic [DIW-1:0]   in_caddr;
    logic [DIW-1:0]   sc_caddr;
    logic [CW-1:0]    pos_raw, pos;
    logic             last_pos;

    assign row_ok  = (in_data.src_row != '0) && (in_data.src_row <= num_rows_reg)
                     && (32'(in_data.src_row) <= 32'(MAX_DIM));
    assign col_ok  = (in_data.src_col != '0) && (in_data.src_col <= num_cols_reg)
                     && (32'(in_data.src_col) <= 32'(MAX_DIM));
    assign room_ok = total_reg < CW'(MAX_ENTRIES);
    assign item_ok = row_ok && col_ok && room_ok;
    assign in_caddr = DIW'(32'(in_data.src_col) - 32'd1);
    assign sc_caddr = DIW'(32'(st_rdata_reg.col) - 32'd1);

    // Slot of the triple being scattered, held inside the matrix.
    assign pos_raw  = col_rdata_reg;
    assign pos      = (pos_raw >= total_reg) ? (total_reg - CW'(1)) : pos_raw;
    assign last_pos = (k_reg == (total_reg - CW'(1)));

    assign in_ready = (state_reg == S_IDLE);

    // Configuration writes.
    always_comb
    begin
        num_rows_next = num_rows_reg;
        num_cols_next = num_cols_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_NUM_ROWS: num_rows_next = cfg_data;
                REG_NUM_COLS: num_cols_next = cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        total_next   = total_reg;
        dropped_next = dropped_reg;
        idx_next     = idx_reg;
        pv_next      = 1'b0;
        pa_next      = pa_reg;
        sum_next     = sum_reg;
        k_next       = k_reg;
        caddr_next   = caddr_reg;
        last_next    = last_reg;
        t_next       = t_reg;
        col_rd_en    = 1'b0;
        col_rd_addr  = '0;
        col_wr_en    = 1'b0;
        col_wr_addr  = '0;
        col_wr_data  = '0;
        st_rd_en     = 1'b0;
        st_rd_addr   = '0;
        st_wr_en     = 1'b0;
        st_wr_addr   = '0;
        st_wr_data   = t_reg;
        ld_en        = 1'b0;
        ld_word      = '0;

        unique case (state_reg)
            // Zero the column memory, one entry a cycle.
            S_CLR:
            begin
                col_wr_en   = 1'b1;
                col_wr_addr = idx_reg[DIW-1:0];
                col_wr_data = '0;
                idx_next    = idx_reg + CNT_W'(1);
                if (idx_reg == CNT_W'(MAX_DIM - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            // Take a word; store an in-range triple and fetch its column count.
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.has_entry && item_ok)
                    begin
                        st_wr_en   = 1'b1;
                        st_wr_addr = SAW'(total_reg);
                        st_wr_data = '{row: in_data.src_row, col: in_data.src_col,
                                       value: in_data.elem_value};
                        col_rd_en   = 1'b1;
                        col_rd_addr = in_caddr;
                        caddr_next  = in_caddr;
                        last_next   = in_data.last_in;
                        state_next  = S_UPD;
                    end
                    else
                    begin
                        if (in_data.has_entry)
                        begin
                            dropped_next = 1'b1;
                        end
                        if (in_data.last_in)
                        begin
                            if (total_reg == '0)
                            begin
                                state_next = S_EMPTY;
                            end
                            else
                            begin
                                state_next = S_PFX;
                                idx_next   = '0;
                                sum_next   = '0;
                            end
                        end
                    end
                end
            end

            // Write back the raised column count.
            S_UPD:
            begin
                col_wr_en   = 1'b1;
                col_wr_addr = caddr_reg;
                col_wr_data = col_rdata_reg + CW'(1);
                total_next  = total_reg + CW'(1);
                if (last_reg)
                begin
                    state_next = S_PFX;
                    idx_next   = '0;
                    sum_next   = '0;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            // Exclusive prefix sum over the counts, written in place.
            S_PFX:
            begin
                if (idx_reg < CNT_W'(MAX_DIM))
                begin
                    col_rd_en   = 1'b1;
                    col_rd_addr = idx_reg[DIW-1:0];
                    pv_next     = 1'b1;
                    pa_next     = idx_reg[DIW-1:0];
                    idx_next    = idx_reg + CNT_W'(1);
                end
                if (pv_reg)
                begin
                    col_wr_en   = 1'b1;
                    col_wr_addr = pa_reg;
                    col_wr_data = sum_reg;
                    sum_next    = sum_reg + col_rdata_reg;
                end
                if ((idx_reg == CNT_W'(MAX_DIM)) && !pv_reg)
                begin
                    state_next = S_SC_RD;
                    k_next     = '0;
                end
            end

            // Fetch the first stored triple.
            S_SC_RD:
            begin
                st_rd_en   = 1'b1;
                st_rd_addr = SAW'(k_reg);
                state_next = S_SC_ST;
            end

            // Hold the triple and fetch the slot offset of its column.
            S_SC_ST:
            begin
                t_next      = st_rdata_reg;
                col_rd_en   = 1'b1;
                col_rd_addr = sc_caddr;
                caddr_next  = sc_caddr;
                state_next  = S_SC_WR;
            end

            // Place the triple in its slot and advance the column offset.
            S_SC_WR:
            begin
                st_wr_en    = 1'b1;
                st_wr_addr  = SAW'(MAX_ENTRIES) + SAW'(pos);
                st_wr_data  = t_reg;
                col_wr_en   = 1'b1;
                col_wr_addr = caddr_reg;
                col_wr_data = pos_raw + CW'(1);
                if (last_pos)
                begin
                    k_next     = '0;
                    state_next = S_EM_RD;
                end
                else
                begin
                    k_next     = k_reg + CW'(1);
                    st_rd_en   = 1'b1;
                    st_rd_addr = SAW'(k_reg + CW'(1));
                    state_next = S_SC_ST;
                end
            end

            // Fetch the first result in output order.
            S_EM_RD:
            begin
                st_rd_en   = 1'b1;
                st_rd_addr = SAW'(MAX_ENTRIES) + SAW'(k_reg);
                state_next = S_EM_LD;
            end

            // Hand results to the output stage, row and column swapped.
            S_EM_LD:
            begin
                if (ld_free)
                begin
                    ld_en   = 1'b1;
                    ld_word = '{out_row: st_rdata_reg.col, out_col: st_rdata_reg.row,
                                out_value: st_rdata_reg.value, out_valid_entry: 1'b1,
                                overflow: dropped_reg, last_out: last_pos};
                    if (last_pos)
                    begin
                        total_next   = '0;
                        dropped_next = 1'b0;
                        idx_next     = '0;
                        state_next   = S_CLR;
                    end
                    else
                    begin
                        k_next     = k_reg + CW'(1);
                        st_rd_en   = 1'b1;
                        st_rd_addr = SAW'(MAX_ENTRIES) + SAW'(k_reg + CW'(1));
                    end
                end
            end

            // Empty matrix: one word without a triple.
            S_EMPTY:
            begin
                if (ld_free)
                begin
                    ld_en   = 1'b1;
                    ld_word = '{out_row: '0, out_col: '0, out_value: '0,
                                out_valid_entry: 1'b0, overflow: dropped_reg,
                                last_out: 1'b1};
                    dropped_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLR;
                idx_next   = '0;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            num_rows_reg <= 7'd64;
            num_cols_reg <= 7'd64;
            total_reg    <= '0;
            dropped_reg  <= 1'b0;
            idx_reg      <= '0;
            pv_reg       <= 1'b0;
            k_reg        <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            num_rows_reg <= num_rows_next;
            num_cols_reg <= num_cols_next;
            total_reg    <= total_next;
            dropped_reg  <= dropped_next;
            idx_reg      <= idx_next;
            pv_reg       <= pv_next;
            k_reg        <= k_next;
            last_reg     <= last_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        pa_reg    <= pa_next;
        sum_reg   <= sum_next;
        caddr_reg <= caddr_next;
        t_reg     <= t_next;
    end

    // Column memory.
    always_ff @(posedge clk)
    begin
        if (col_wr_en)
        begin
            col_mem[col_wr_addr] <= col_wr_data;
        end
        if (col_rd_en)
        begin
            col_rdata_reg <= col_mem[col_rd_addr];
        end
    end

    // Triple memory.
    always_ff @(posedge clk)
    begin
        if (st_wr_en)
        begin
            st_mem[st_wr_addr] <= st_wr_data;
        end
        if (st_rd_en)
        begin
            st_rdata_reg <= st_mem[st_rd_addr];
        end
    end

    // Output register.
    sstr_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (ld_en),
        .word      (ld_word),
        .free      (ld_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Column offsets never point past the triples of the matrix.
    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SC_WR) |-> (col_rdata_reg < total_reg))
        else $error("scatter slot outside the matrix");

    // The stored triple count never exceeds the store.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CW'(MAX_ENTRIES))
        else $error("triple count above store size");

    // Emission only reads slots that were filled.
    a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EM_LD) |-> (k_reg < total_reg))
        else $error("emission index outside the matrix");

    // The final result carries the last mark and starts the clearing pass.
    a_last_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EM_LD && ld_free && last_pos)
        |=> (state_reg == S_CLR && out_valid && out_data.last_out))
        else $error("final result not marked or clearing not started");

endmodule

`default_nettype wire

/* src/sstr_out_stage.sv */
// ----------------------------------------------------------------------------
// Sparse triple transpose output stage
// Output register that holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sstr_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire sstr_pkg::out_word_t word,
    output logic                    free,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output sstr_pkg::out_word_t     out_data
);
    import sstr_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_word_t data_reg;

    // The stage can take a new word when empty or when its word leaves now.
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid flag with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= word;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* tb/sv/tb_sparse_triple_fast_transpose.sv */
// ----------------------------------------------------------------------------
// Sparse triple fast transpose testbench
// Streams coordinate triples into the block, predicts the transposed words
// and checks every result word field by field against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sparse_triple_fast_transpose;

    import sstr_pkg::*;

    localparam int MAX_ENTRIES = 64;
    localparam int MAX_DIM     = 64;
    localparam int TOTAL_WORDS = 230;
    localparam int CYCLE_LIMIT = 2000000;

    // Clock, reset and block inputs, all known from time zero.
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_wr_en = 1'b0;
    cfg_idx_t  cfg_index = REG_NUM_ROWS;
    logic [6:0] cfg_data = '0;
    logic      in_valid  = 1'b0;
    in_word_t  in_data   = '0;
    logic      out_ready = 1'b1;
    logic      in_ready;
    logic      out_valid;
    out_word_t out_data;

    // Predictor state: register copies, held triples and the expected words.
    logic [6:0] rows_reg = 7'd64;
    logic [6:0] cols_reg = 7'd64;
    triple_t    held_triples[$];
    bit         any_dropped = 1'b0;
    out_word_t  expected_words[$];
    out_word_t  want_word;

    int error_count = 0;
    int words_sent  = 0;
    int cycle_count = 0;
    int gap_pct     = 25;
    int stall_pct   = 20;
    int hold_left   = 0;

    sparse_triple_fast_transpose #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_DIM     (MAX_DIM)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver back-pressure in random bursts.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct / 4)
        begin
            hold_left = $urandom_range(0, 18);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // A register value above the largest dimension acts as that dimension.
    function automatic int dim_limit(input logic [6:0] reg_val);
        return (reg_val > MAX_DIM) ? MAX_DIM : int'(reg_val);
    endfunction

    function automatic in_word_t make_word(input logic [6:0] row, input logic [6:0] col,
                                           input logic [31:0] value, input bit has,
                                           input bit last);
        in_word_t w;
        w.src_row    = row;
        w.src_col    = col;
        w.elem_value = value;
        w.has_entry  = has;
        w.last_in    = last;
        return w;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [6:0] pick_dim();
        case ($urandom_range(0, 19))
            0:       return 7'd0;
            1:       return 7'($urandom_range(65, 127));
            2:       return 7'd1;
            3:       return 7'd64;
            default: return 7'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    // Update the predicted matrix with one accepted word; on the last word,
    // queue the transposed triples by source column, arrival order kept.
    function automatic void transpose_word(input in_word_t w);
        out_word_t o;
        triple_t   t;
        int        n;
        int        k;
        if (w.has_entry)
        begin
            if (w.src_row == 0 || w.src_row > dim_limit(rows_reg) ||
                w.src_col == 0 || w.src_col > dim_limit(cols_reg) ||
                held_triples.size() >= MAX_ENTRIES)
            begin
                any_dropped = 1'b1;
            end
            else
            begin
                t.row   = w.src_row;
                t.col   = w.src_col;
                t.value = w.elem_value;
                held_triples.push_back(t);
            end
        end
        if (w.last_in)
        begin
            n = held_triples.size();
            if (n == 0)
            begin
                o = '0;
                o.overflow = any_dropped;
                o.last_out = 1'b1;
                expected_words.push_back(o);
            end
            else
            begin
                k = 0;
                for (int c = 1; c <= MAX_DIM; c++)
                begin
                    foreach (held_triples[i])
                    begin
                        if (held_triples[i].col == c)
                        begin
                            o.out_row         = held_triples[i].col;
                            o.out_col         = held_triples[i].row;
                            o.out_value       = held_triples[i].value;
                            o.out_valid_entry = 1'b1;
                            o.overflow        = any_dropped;
                            o.last_out        = (k == n - 1);
                            expected_words.push_back(o);
                            k++;
                        end
                    end
                end
            end
            held_triples.delete();
            any_dropped = 1'b0;
        end
    endfunction

    // Send one word, with an optional idle burst before it.
    task automatic send_word(input in_word_t w);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        transpose_word(w);
        if (w.has_entry || w.last_in)
            words_sent++;
    endtask

    task automatic send_triple(input logic [6:0] row, input logic [6:0] col,
                               input logic [31:0] value, input bit last);
        send_word(make_word(row, col, value, 1'b1, last));
    endtask

    // Wait until every expected word has come and the clearing pass is over.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (MAX_DIM + 24) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [6:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == REG_NUM_ROWS)
            rows_reg = value;
        else
            cols_reg = value;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Compare each accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("result word with nothing expected: row %0d col %0d",
                       out_data.out_row, out_data.out_col);
                error_count++;
            end
            else
            begin
                want_word = expected_words.pop_front();
                check_field("out_row", 32'(want_word.out_row), 32'(out_data.out_row));
                check_field("out_col", 32'(want_word.out_col), 32'(out_data.out_col));
                check_field("out_value", want_word.out_value, out_data.out_value);
                check_field("out_valid_entry", 32'(want_word.out_valid_entry),
                            32'(out_data.out_valid_entry));
                check_field("overflow", 32'(want_word.overflow),
                            32'(out_data.overflow));
                check_field("last_out", 32'(want_word.last_out),
                            32'(out_data.last_out));
            end
        end
    end

    // Corner indexes and values; shared columns check the order within a column.
    task automatic test_corner_entries();
        send_triple(7'd1, 7'd1, 32'h7FFF_FFFF, 1'b0);
        send_triple(7'd1, 7'd64, 32'h8000_0000, 1'b0);
        send_word(make_word(7'd127, 7'd127, 32'hFFFF_FFFF, 1'b0, 1'b0));
        send_triple(7'd2, 7'd3, 32'h0000_0001, 1'b0);
        send_triple(7'd64, 7'd1, 32'hFFFF_FFFF, 1'b0);
        send_triple(7'd64, 7'd64, 32'h0000_0000, 1'b1);
    endtask

    // Empty matrices and triples dropped for bad indexes.
    task automatic test_empty_and_dropped();
        send_word(make_word(7'd0, 7'd0, 32'h0, 1'b0, 1'b1));
        send_triple(7'd0, 7'd5, $urandom, 1'b0);
        send_triple(7'd5, 7'd0, $urandom, 1'b0);
        send_triple(7'd65, 7'd1, $urandom, 1'b0);
        send_triple(7'd1, 7'd65, $urandom, 1'b0);
        send_triple(7'd10, 7'd10, $urandom, 1'b1);
        send_triple(7'd127, 7'd127, $urandom, 1'b1);
    endtask

    // Small, zero and oversized register settings.
    task automatic test_register_limits();
        settle();
        write_reg(REG_NUM_ROWS, 7'd3);
        write_reg(REG_NUM_COLS, 7'd5);
        send_triple(7'd1, 7'd5, $urandom, 1'b0);
        send_triple(7'd3, 7'd1, $urandom, 1'b0);
        send_triple(7'd4, 7'd2, $urandom, 1'b1);
        settle();
        write_reg(REG_NUM_ROWS, 7'd0);
        write_reg(REG_NUM_COLS, 7'd0);
        send_triple(7'd1, 7'd1, $urandom, 1'b1);
        settle();
        write_reg(REG_NUM_ROWS, 7'd127);
        write_reg(REG_NUM_COLS, 7'd127);
        send_triple(7'd64, 7'd64, $urandom, 1'b0);
        send_triple(7'd65, 7'd1, $urandom, 1'b1);
        settle();
        write_reg(REG_NUM_ROWS, 7'd1);
        write_reg(REG_NUM_COLS, 7'd1);
        send_triple(7'd1, 7'd1, $urandom, 1'b0);
        send_triple(7'd1, 7'd2, $urandom, 1'b1);
        settle();
        write_reg(REG_NUM_ROWS, 7'd64);
        write_reg(REG_NUM_COLS, 7'd64);
    endtask

    // A column limit lowered within a matrix leaves earlier triples stored.
    task automatic test_register_change_mid_matrix();
        send_triple(7'd1, 7'd40, $urandom, 1'b0);
        in_valid <= 1'b0;
        repeat (12) @(posedge clk);
        write_reg(REG_NUM_COLS, 7'd10);
        send_triple(7'd2, 7'd40, $urandom, 1'b0);
        send_triple(7'd2, 7'd5, $urandom, 1'b1);
        settle();
        write_reg(REG_NUM_COLS, 7'd64);
    endtask

    // More triples than the store holds; the last word itself is dropped.
    task automatic test_store_full();
        int unsigned p;
        p = $urandom_range(0, 3);
        for (int i = 0; i < MAX_ENTRIES + 3; i++)
        begin
            send_triple(7'(p / MAX_DIM + 1), 7'(p % MAX_DIM + 1), pick_value(),
                        i == MAX_ENTRIES + 2);
            p += $urandom_range(1, 60);
        end
    endtask

    // Random matrices: mostly row-major with random content, some noise.
    task automatic test_random_matrices();
        int unsigned cells[$];
        int unsigned p;
        int          n;
        int          r_eff;
        int          c_eff;
        int          area;
        int          step_max;
        bit          split_end;
        while (words_sent < TOTAL_WORDS)
        begin
            if (words_sent >= TOTAL_WORDS - 40)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                gap_pct   = pick_pct();
                stall_pct = pick_pct();
            end
            if ($urandom_range(0, 4) == 0)
            begin
                settle();
                write_reg(REG_NUM_ROWS, pick_dim());
                write_reg(REG_NUM_COLS, pick_dim());
            end
            r_eff = (dim_limit(rows_reg) == 0) ? 1 : dim_limit(rows_reg);
            c_eff = (dim_limit(cols_reg) == 0) ? 1 : dim_limit(cols_reg);
            if ($urandom_range(0, 9) < 8)
            begin
                // Well-formed matrix at distinct row-major positions.
                area = r_eff * c_eff;
                n = ($urandom_range(0, 11) == 0) ? $urandom_range(40, 70)
                                                 : $urandom_range(0, 10);
                step_max = (2 * area) / (n + 1);
                if (step_max < 1)
                    step_max = 1;
                cells.delete();
                p = $urandom_range(0, step_max - 1);
                while (cells.size() < n && p < area)
                begin
                    cells.push_back(p);
                    p += $urandom_range(1, step_max);
                end
                split_end = (cells.size() == 0) || ($urandom_range(0, 5) == 0);
                foreach (cells[i])
                begin
                    send_triple(7'(cells[i] / c_eff + 1), 7'(cells[i] % c_eff + 1),
                                pick_value(), !split_end && i == cells.size() - 1);
                end
                if (split_end)
                    send_word(make_word(7'($urandom_range(0, 127)),
                                        7'($urandom_range(0, 127)),
                                        $urandom, 1'b0, 1'b1));
            end
            else
            begin
                // Noise: unordered, out-of-range and empty words.
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                begin
                    send_word(make_word(
                        7'($urandom_range(0, 1) ? $urandom_range(0, 127)
                                                : $urandom_range(1, r_eff)),
                        7'($urandom_range(0, 1) ? $urandom_range(0, 127)
                                                : $urandom_range(1, c_eff)),
                        pick_value(), $urandom_range(0, 7) != 0, i == n - 1));
                end
            end
        end
    endtask

    // Test sequence.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (MAX_DIM + 16) @(posedge clk);
        test_corner_entries();
        test_empty_and_dropped();
        test_register_limits();
        test_register_change_mid_matrix();
        test_store_full();
        test_random_matrices();
        settle();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
